>>> sv/otsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared constants and types for the Otsu threshold block.
// ----------------------------------------------------------------------------
package otsu_pkg;

  localparam int unsigned COUNT_LOG2 = 20;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned CNT_W      = COUNT_LOG2 + 1;
  localparam int unsigned SUM_W      = CNT_W + LVL_W;
  localparam int unsigned WPROD_W    = 2 * CNT_W;
  localparam int unsigned DSQ_W      = 2 * LVL_W;
  localparam int unsigned SCORE_W    = WPROD_W + DSQ_W;
  localparam int unsigned STEP_W     = $clog2(LVL_W);

  localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 2);

  // Request bundle from the controller to the histogram store.
  typedef struct packed {
    logic             acc_valid;
    logic [LVL_W-1:0] acc_addr;
    logic [LVL_W-1:0] rd_addr;
    logic             clr;
  } hist_req_t;

endpackage

>>> sv/ot_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ot_hist
// 256-bin histogram in a synchronous RAM with a read-modify-write pipeline,
// write forwarding and per-bin valid bits so the whole store clears at once.
// ----------------------------------------------------------------------------
module ot_hist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  otsu_pkg::hist_req_t       req_i,
  output logic [otsu_pkg::CNT_W-1:0] rd_data_o
);

  logic [otsu_pkg::CNT_W-1:0] mem_q [otsu_pkg::LEVELS];
  logic [otsu_pkg::LEVELS-1:0] vld_q;

  logic [otsu_pkg::CNT_W-1:0] rd_q;
  logic                       rd_vld_q;
  logic [otsu_pkg::LVL_W-1:0] raddr;

  logic                       b_valid_q;
  logic [otsu_pkg::LVL_W-1:0] b_addr_q;
  logic                       w_valid_q;
  logic [otsu_pkg::LVL_W-1:0] w_addr_q;
  logic [otsu_pkg::CNT_W-1:0] w_data_q;

  logic [otsu_pkg::CNT_W-1:0] old_cnt;
  logic [otsu_pkg::CNT_W-1:0] new_cnt;

  assign raddr     = req_i.acc_valid ? req_i.acc_addr : req_i.rd_addr;
  assign rd_data_o = rd_vld_q ? rd_q : '0;

  // The write of the previous cycle is not yet visible in the read data.
  assign old_cnt = (w_valid_q && (w_addr_q == b_addr_q)) ? w_data_q : rd_data_o;
  assign new_cnt = old_cnt + otsu_pkg::CNT_W'(1);

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    if (b_valid_q) begin
      mem_q[b_addr_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    w_addr_q <= b_addr_q;
    w_data_q <= new_cnt;
    b_addr_q <= req_i.acc_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      b_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= vld_q[raddr];
      b_valid_q <= req_i.acc_valid;
      w_valid_q <= b_valid_q;
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (b_valid_q) begin
        vld_q[b_addr_q] <= 1'b1;
      end
    end
  end

  a_clr_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clr |-> !b_valid_q && !req_i.acc_valid)
    else $error("histogram cleared with an update in flight");

  a_fwd_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |=> w_valid_q)
    else $error("write forwarding lost track of a write");

  a_written_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !req_i.clr) |=> vld_q[$past(b_addr_q)])
    else $error("written bin not marked valid");

endmodule

>>> sv/ot_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ot_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// 8 bits (dividend < 256 * divisor), which holds for class means.
// ----------------------------------------------------------------------------
module ot_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [otsu_pkg::SUM_W-1:0]  dividend_i,
  input  logic [otsu_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [otsu_pkg::LVL_W-1:0]  quot_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [otsu_pkg::STEP_W-1:0] step_q;
  logic [otsu_pkg::SUM_W-1:0]  rem_q, rem_d;
  logic [otsu_pkg::CNT_W-1:0]  dvs_q;
  logic [otsu_pkg::LVL_W-1:0]  quot_q, quot_d;
  logic [otsu_pkg::SUM_W-1:0]  trial;

  assign trial = otsu_pkg::SUM_W'(dvs_q) << step_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    if (rem_q >= trial) begin
      rem_d          = rem_q - trial;
      quot_d[step_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dvs_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= otsu_pkg::STEP_W'(otsu_pkg::LVL_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - otsu_pkg::STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("divide by zero");

endmodule

>>> sv/otsu_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold
// Otsu threshold of an 8-bit gray image from a 256-bin histogram.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low; last_i ends the image.
// After the last pixel and a drain state the block scans thresholds 0..254
// (histogram RAM read, update, mean division if both classes are non-empty,
// two multiply stages, compare), ending early once class two is empty; busy is
// high meanwhile. The result shows on threshold_o for one cycle with valid_o
// and cannot be held off. The histogram is then cleared at once by valid
// bits and the next image may start. Pixels beyond 2^20 are dropped.
module otsu_threshold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [otsu_pkg::LVL_W-1:0]    pixel_i,
  input  logic                          last_i,
  output logic                          valid_o,
  output logic [otsu_pkg::LVL_W-1:0]    threshold_o
);

  typedef enum logic [8:0] {
    S_ACCUM = 9'b000000001,
    S_DRAIN = 9'b000000010,
    S_READ  = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MUL1  = 9'b001000000,
    S_MUL2  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [otsu_pkg::CNT_W-1:0]   count_q;
  logic [otsu_pkg::SUM_W-1:0]   total_q;
  logic [otsu_pkg::CNT_W-1:0]   low_w_q;
  logic [otsu_pkg::SUM_W-1:0]   low_sum_q;
  logic [otsu_pkg::CNT_W-1:0]   high_q;
  logic [otsu_pkg::SCORE_W-1:0] best_score_q;
  logic [otsu_pkg::LVL_W-1:0]   best_level_q;
  logic [otsu_pkg::LVL_W-1:0]   scan_level_q;
  logic [otsu_pkg::WPROD_W-1:0] wprod_q;
  logic [otsu_pkg::DSQ_W-1:0]   dsq_q;
  logic [otsu_pkg::SCORE_W-1:0] score_q;
  logic                         score_vld_q;

  logic                         accept;
  logic                         take;
  otsu_pkg::hist_req_t          hreq;
  logic [otsu_pkg::CNT_W-1:0]   cnt;
  logic [otsu_pkg::CNT_W-1:0]   high_d;
  logic                         div_start;
  logic                         div1_done;
  logic                         div2_done;
  logic [otsu_pkg::LVL_W-1:0]   mean1;
  logic [otsu_pkg::LVL_W-1:0]   mean2;
  logic [otsu_pkg::LVL_W-1:0]   diff;
  logic                         scan_done;

  assign accept = start && !busy;
  assign take   = accept && !count_q[otsu_pkg::COUNT_LOG2];
  assign busy   = (state_q != S_ACCUM);

  assign hreq.acc_valid = take;
  assign hreq.acc_addr  = pixel_i;
  assign hreq.rd_addr   = scan_level_q;
  assign hreq.clr       = (state_q == S_EMIT);

  ot_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hreq),
    .rd_data_o (cnt)
  );

  assign high_d    = count_q - low_w_q;
  assign div_start = (state_q == S_CHK) && (low_w_q != '0) && (high_d != '0);

  ot_div u_div_low (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (low_sum_q),
    .divisor_i  (low_w_q),
    .done_o     (div1_done),
    .quot_o     (mean1)
  );

  ot_div u_div_high (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q - low_sum_q),
    .divisor_i  (high_d),
    .done_o     (div2_done),
    .quot_o     (mean2)
  );

  assign diff = (mean1 > mean2) ? (mean1 - mean2) : (mean2 - mean1);

  // Level 254 was scored; the read cycle that follows only resolves its score.
  assign scan_done = (scan_level_q == otsu_pkg::LVL_W'(otsu_pkg::LEVELS - 1));

  // Stop after the last level, or once class two has emptied.
  function automatic logic scan_end_next(input logic [otsu_pkg::CNT_W-1:0] high);
    scan_end_next = (scan_level_q == otsu_pkg::LAST_LEVEL) || (high == '0);
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_ACCUM: if (accept && last_i) state_d = S_DRAIN;
      S_DRAIN: state_d = (count_q == '0) ? S_EMIT : S_READ;
      S_READ:  state_d = scan_done ? S_EMIT : S_UPD;
      S_UPD:   state_d = S_CHK;
      S_CHK:   state_d = div_start ? S_DIV : (scan_end_next(high_d) ? S_EMIT : S_READ);
      S_DIV:   if (div1_done && div2_done) state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_READ;
      S_EMIT:  state_d = S_ACCUM;
      default: state_d = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL1) begin
      wprod_q <= low_w_q * high_q;
      dsq_q   <= diff * diff;
    end
    if (state_q == S_MUL2) begin
      score_q <= wprod_q * dsq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_ACCUM;
      count_q      <= '0;
      total_q      <= '0;
      low_w_q      <= '0;
      low_sum_q    <= '0;
      high_q       <= '0;
      best_score_q <= '0;
      best_level_q <= '0;
      scan_level_q <= '0;
      score_vld_q  <= 1'b0;
      valid_o      <= 1'b0;
      threshold_o  <= '0;
    end else begin
      state_q     <= state_d;
      valid_o     <= (state_d == S_EMIT) && (state_q != S_EMIT);
      score_vld_q <= (state_q == S_MUL2);
      if (take) begin
        count_q <= count_q + otsu_pkg::CNT_W'(1);
        total_q <= total_q + otsu_pkg::SUM_W'(pixel_i);
      end
      if (score_vld_q && (score_q > best_score_q)) begin
        best_score_q <= score_q;
        best_level_q <= scan_level_q - otsu_pkg::LVL_W'(1);
      end
      unique case (state_q)
        S_UPD: begin
          low_w_q   <= low_w_q + cnt;
          low_sum_q <= low_sum_q
                       + otsu_pkg::SUM_W'(scan_level_q) * otsu_pkg::SUM_W'(cnt);
        end
        S_CHK: begin
          high_q <= high_d;
          if (!div_start) begin
            scan_level_q <= scan_level_q + otsu_pkg::LVL_W'(1);
          end
        end
        S_MUL1: begin
          scan_level_q <= scan_level_q + otsu_pkg::LVL_W'(1);
        end
        S_EMIT: begin
          count_q      <= '0;
          total_q      <= '0;
          low_w_q      <= '0;
          low_sum_q    <= '0;
          high_q       <= '0;
          best_score_q <= '0;
          best_level_q <= '0;
          scan_level_q <= '0;
        end
        default: ;
      endcase
      if (state_d == S_EMIT && state_q != S_EMIT) begin
        // A score still in flight from the last level is resolved here.
        if (score_vld_q && (score_q > best_score_q)) begin
          threshold_o <= scan_level_q - otsu_pkg::LVL_W'(1);
        end else begin
          threshold_o <= best_level_q;
        end
      end
    end
  end

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobed while idle");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> busy)
    else $error("scan did not start after the last pixel");

  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy && !valid_o)
    else $error("block not idle after the result");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (scan_level_q <= otsu_pkg::LAST_LEVEL))
    else $error("scan read beyond the last threshold");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Otsu threshold block.
// ----------------------------------------------------------------------------
// Pixels are sent in images of mostly small size, with a directed set first,
// then random images: uniform, two-cluster, few-level and single-level
// content. A scoreboard keeps its own histogram, runs the exact integer Otsu
// scan on each last pixel and checks every threshold.
// ----------------------------------------------------------------------------
module tb_top;

  class otsu_scoreboard;
    int unsigned                 hist[otsu_pkg::LEVELS];
    int unsigned                 npix;
    int unsigned                 level_sum;
    logic [otsu_pkg::LVL_W-1:0]  thr_q[$];
    int                          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      foreach (hist[i]) hist[i] = 0;
      npix      = 0;
      level_sum = 0;
    endfunction

    // exact integer scan; first strictly larger score wins
    function logic [otsu_pkg::LVL_W-1:0] otsu_scan();
      int unsigned                 w1, s1, w2, cnt, m1, m2, d;
      longint unsigned             score, best;
      logic [otsu_pkg::LVL_W-1:0]  best_lvl;
      int unsigned                 lvl;
      w1 = 0; s1 = 0; best = 0; best_lvl = '0; lvl = 0; w2 = npix;
      while (lvl < otsu_pkg::LEVELS - 1 && w2 != 0) begin
        cnt = hist[lvl];
        w1 += cnt;
        w2 = npix - w1;
        if (w1 != 0 && w2 != 0) begin
          s1 += lvl * cnt;
          m1 = (s1 / w1) & 8'hff;
          m2 = ((level_sum - s1) / w2) & 8'hff;
          d  = (m1 > m2) ? m1 - m2 : m2 - m1;
          score = longint'(w1) * longint'(w2) * longint'(d * d);
          if (score > best) begin
            best     = score;
            best_lvl = lvl[otsu_pkg::LVL_W-1:0];
          end
        end
        lvl++;
      end
      return best_lvl;
    endfunction

    function void note_pixel(logic [otsu_pkg::LVL_W-1:0] px, logic lst);
      if (npix < (1 << otsu_pkg::COUNT_LOG2)) begin
        hist[px]++;
        npix++;
        level_sum += px;
      end
      if (lst) begin
        thr_q.push_back(otsu_scan());
        clear();
      end
    endfunction

    function void check_threshold(logic [otsu_pkg::LVL_W-1:0] got);
      logic [otsu_pkg::LVL_W-1:0] want;
      if (thr_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected threshold %0d", got);
        return;
      end
      want = thr_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("threshold mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [otsu_pkg::LVL_W-1:0]  pixel_i;
  logic                        last_i;
  logic                        valid_o;
  logic [otsu_pkg::LVL_W-1:0]  threshold_o;

  otsu_scoreboard sb = new();
  bit             quiet;  // no idle gaps in the final stretch

  otsu_threshold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_i),
    .last_i      (last_i),
    .valid_o     (valid_o),
    .threshold_o (threshold_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_threshold(threshold_o);
  end

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
  endtask

  // one pixel transfer; returns after acceptance, or once checked if it is last
  task automatic send_pixel(logic [otsu_pkg::LVL_W-1:0] px, logic lst,
                            bit may_idle = 1'b1);
    if (may_idle) idle_burst();
    start   = 1'b1;
    pixel_i = px;
    last_i  = lst;
    // busy only moves at rising edges, so its value here holds at the next one
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_pixel(px, lst);
    @(negedge clk_i);
    if (lst) begin
      start = 1'b0;
      while (sb.thr_q.size() != 0) @(negedge clk_i);
    end
  endtask

  // kind: 0 uniform, 1 two clusters, 2 few levels, 3 single level
  task automatic send_image(int unsigned len, int unsigned kind);
    logic [otsu_pkg::LVL_W-1:0] a, b, px;
    a = otsu_pkg::LVL_W'($urandom);
    b = otsu_pkg::LVL_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        0: px = otsu_pkg::LVL_W'($urandom);
        1: px = $urandom_range(0, 1) ? a + otsu_pkg::LVL_W'($urandom_range(0, 12))
                                     : b - otsu_pkg::LVL_W'($urandom_range(0, 12));
        2: px = $urandom_range(0, 1) ? a : b;
        default: px = a;
      endcase
      send_pixel(px, i == len - 1);
    end
  endtask

  int unsigned sent;
  int unsigned len;

  initial begin
    start = 1'b0; pixel_i = '0; last_i = 1'b0; quiet = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: single pixel, extremes, one level, bare last
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b1);
    send_pixel(8'd7, 1'b0); send_pixel(8'd7, 1'b0); send_pixel(8'd7, 1'b1);
    send_pixel(8'd254, 1'b0); send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0); send_pixel(8'd1, 1'b1);
    send_pixel(8'd0, 1'b0); send_pixel(8'd254, 1'b0); send_pixel(8'd255, 1'b1);
    send_pixel(8'haa, 1'b0); send_pixel(8'h55, 1'b0); send_pixel(8'hf0, 1'b0);
    send_pixel(8'h0f, 1'b1);

    sent = 0;
    while (sent < 1330) begin
      if (sent > 1150) quiet = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      send_image(len, $urandom_range(0, 3));
      sent += len;
    end

    start = 1'b0;
    while (sb.thr_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
sv/otsu_pkg.sv
sv/ot_hist.sv
sv/ot_div.sv
sv/otsu_threshold.sv
tb/tb_top.sv
